// ===== sv/div128_pkg.sv =====
package div128_pkg;

  // Each operand and result travels as two halves of this width.
  localparam int unsigned HalfW = 64;
  localparam int unsigned FullW = 2 * HalfW;

  // Default operand width; the core accepts 8 to FullW bits.
  localparam int unsigned OperandWidthDef = FullW;

  // Sequencer states of the divider core.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage

// ===== sv/div128_req_if.sv =====
interface div128_req_if;
  import div128_pkg::*;

  logic             valid;
  logic             ready;
  logic [HalfW-1:0] dividend_hi;
  logic [HalfW-1:0] dividend_lo;
  logic [HalfW-1:0] divisor_hi;
  logic [HalfW-1:0] divisor_lo;

  modport source (
    output valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
    input  ready
  );

  modport sink (
    input  valid, dividend_hi, dividend_lo, divisor_hi, divisor_lo,
    output ready
  );

endinterface

// ===== sv/div128_rsp_if.sv =====
interface div128_rsp_if;
  import div128_pkg::*;

  logic             valid;
  logic             ready;
  logic [HalfW-1:0] quotient_hi;
  logic [HalfW-1:0] quotient_lo;
  logic [HalfW-1:0] remainder_hi;
  logic [HalfW-1:0] remainder_lo;
  logic             divide_by_zero;

  modport source (
    output valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo, divide_by_zero,
    input  ready
  );

  modport sink (
    input  valid, quotient_hi, quotient_lo, remainder_hi, remainder_lo, divide_by_zero,
    output ready
  );

endinterface

// ===== sv/divider_128bit_unsigned_core.sv =====
// Sequence: a taken request beat loads the operands, ST_RUN steps through every quotient bit, and
// ST_DONE passes the result into the result register once it is free. The single shared
// subtractor resolves one quotient bit per cycle; a new division starts only from idle.
// The request side is ready only while idle; the result register lets a new request start
// while the previous result still waits. Reset clears the sequencer and the result valid.
module divider_128bit_unsigned_core #(
  parameter int unsigned OPERAND_WIDTH = div128_pkg::OperandWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  div128_req_if.sink  req_i,
  div128_rsp_if.source rsp_o
);
  import div128_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    den_q, den_d;
  logic            dz_q, dz_d;

  logic             rsp_valid_q, rsp_valid_d;
  logic [FullW-1:0] rsp_quo_q, rsp_quo_d;
  logic [FullW-1:0] rsp_rem_q, rsp_rem_d;
  logic             rsp_dz_q, rsp_dz_d;

  logic [FullW-1:0] dividend_full;
  logic [FullW-1:0] divisor_full;
  logic [W:0]       rem_shift;
  logic [W:0]       rem_trial;
  logic             rsp_free;

  // Operands are cut to the configured width; higher input bits are ignored.
  assign dividend_full = {req_i.dividend_hi, req_i.dividend_lo};
  assign divisor_full  = {req_i.divisor_hi, req_i.divisor_lo};

  // Shared shift-subtract unit: bring down the next dividend bit and try the divisor.
  assign rem_shift = {rem_q, quo_q[W-1]};
  assign rem_trial = rem_shift - {1'b0, den_q};

  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    dz_d        = dz_q;
    rsp_valid_d = rsp_valid_q;
    rsp_quo_d   = rsp_quo_q;
    rsp_rem_d   = rsp_rem_q;
    rsp_dz_d    = rsp_dz_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          rem_d   = '0;
          quo_d   = dividend_full[W-1:0];
          den_d   = divisor_full[W-1:0];
          dz_d    = (divisor_full[W-1:0] == '0);
          cnt_d   = CntW'(W - 1);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        // A zero divisor always subtracts, leaving all-ones and the dividend.
        if (!rem_trial[W]) begin
          rem_d = rem_trial[W-1:0];
        end else begin
          rem_d = rem_shift[W-1:0];
        end
        quo_d = {quo_q[W-2:0], !rem_trial[W]};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_quo_d   = FullW'(quo_q);
          rsp_rem_d   = FullW'(rem_q);
          rsp_dz_d    = dz_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    dz_q      <= dz_d;
    rsp_quo_q <= rsp_quo_d;
    rsp_rem_q <= rsp_rem_d;
    rsp_dz_q  <= rsp_dz_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.quotient_hi    = rsp_quo_q[FullW-1:HalfW];
  assign rsp_o.quotient_lo    = rsp_quo_q[HalfW-1:0];
  assign rsp_o.remainder_hi   = rsp_rem_q[FullW-1:HalfW];
  assign rsp_o.remainder_lo   = rsp_rem_q[HalfW-1:0];
  assign rsp_o.divide_by_zero = rsp_dz_q;

  // The partial remainder stays below a nonzero divisor through every step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !dz_q) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

  // A taken request starts a full run of steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ST_RUN && cnt_q == CntW'(W - 1)))
    else $error("run did not start after request beat");

  // A new result only appears out of the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result valid raised outside finish");

  // A zero divisor ends with an all-ones quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && dz_q) |-> (&quo_q))
    else $error("zero divisor did not give all-ones quotient");

endmodule
